/* design/fplc_pkg.sv */
// shared types, widths and format codes for the frame plane layout calculator
// no dependencies; imported by the interfaces and every module of the block
package fplc_pkg;

  // default frame limits and plane count
  localparam int MAX_WIDTH_DEF  = 8192;
  localparam int MAX_HEIGHT_DEF = 8192;
  localparam int MAX_PLANES     = 4;

  // field widths of the request and result channels
  localparam int FW_W     = 14;
  localparam int FH_W     = 14;
  localparam int FMT_W    = 5;
  localparam int ALIGN_W  = 13;
  localparam int BASE_W   = 32;
  localparam int PIDX_W   = $clog2(MAX_PLANES);
  localparam int STRIDE_W = 16;
  localparam int ROWS_W   = 14;
  localparam int ADDR_W   = 33;
  localparam int TOTAL_W  = 30;

  // unaligned row bytes, clamped just above the stride range
  localparam int                RAW_W      = STRIDE_W + 1;
  localparam logic [RAW_W-1:0]  RAW_MAX    = RAW_W'(1) << STRIDE_W;
  localparam logic [STRIDE_W-1:0] STRIDE_MAX = '1;
  localparam logic [ROWS_W-1:0] ROWS_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // product and running sums in the plane emitter
  localparam int PROD_W = STRIDE_W + ROWS_W;
  localparam int ACC_W  = PROD_W + 2;

  // alignment remainder unit: digit width in bits and step count
  localparam int DIG_W     = 5;
  localparam int DIV_STEPS = (RAW_W + DIG_W - 1) / DIG_W;
  localparam int PAD_W     = DIV_STEPS * DIG_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // queue between the alignment unit and the plane emitter
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // pixel format codes
  localparam logic [FMT_W-1:0] FMT_YUV420P     = 5'd0;
  localparam logic [FMT_W-1:0] FMT_YUV420P9    = 5'd1;
  localparam logic [FMT_W-1:0] FMT_YUV420P10   = 5'd2;
  localparam logic [FMT_W-1:0] FMT_YUV420P12   = 5'd3;
  localparam logic [FMT_W-1:0] FMT_YUV420P14   = 5'd4;
  localparam logic [FMT_W-1:0] FMT_YUV420P16   = 5'd5;
  localparam logic [FMT_W-1:0] FMT_YUV422P     = 5'd6;
  localparam logic [FMT_W-1:0] FMT_YUV422P9    = 5'd7;
  localparam logic [FMT_W-1:0] FMT_YUV422P10   = 5'd8;
  localparam logic [FMT_W-1:0] FMT_YUV422P12   = 5'd9;
  localparam logic [FMT_W-1:0] FMT_YUV422P14   = 5'd10;
  localparam logic [FMT_W-1:0] FMT_YUV422P16   = 5'd11;
  localparam logic [FMT_W-1:0] FMT_YUV444P     = 5'd12;
  localparam logic [FMT_W-1:0] FMT_YUV444P9    = 5'd13;
  localparam logic [FMT_W-1:0] FMT_YUV444P10   = 5'd14;
  localparam logic [FMT_W-1:0] FMT_YUV444P12   = 5'd15;
  localparam logic [FMT_W-1:0] FMT_YUV444P14   = 5'd16;
  localparam logic [FMT_W-1:0] FMT_YUV444P16   = 5'd17;
  localparam logic [FMT_W-1:0] FMT_NV12        = 5'd18;
  localparam logic [FMT_W-1:0] FMT_NV21        = 5'd19;
  localparam logic [FMT_W-1:0] FMT_P016        = 5'd20;
  localparam logic [FMT_W-1:0] FMT_NV16        = 5'd21;
  localparam logic [FMT_W-1:0] FMT_NV24        = 5'd22;
  localparam logic [FMT_W-1:0] FMT_NV42        = 5'd23;
  localparam logic [FMT_W-1:0] FMT_GRAY8       = 5'd24;
  localparam logic [FMT_W-1:0] FMT_GRAY16      = 5'd25;
  localparam logic [FMT_W-1:0] FMT_GRAYF32     = 5'd26;
  localparam logic [FMT_W-1:0] FMT_RGB24       = 5'd27;
  localparam logic [FMT_W-1:0] FMT_BGR24       = 5'd28;
  localparam logic [FMT_W-1:0] FMT_RGB32       = 5'd29;
  localparam logic [FMT_W-1:0] FMT_BGR32       = 5'd30;

  // classified request: unaligned luma and chroma row bytes and rows
  typedef struct packed {
    logic [RAW_W-1:0]   s0;
    logic [RAW_W-1:0]   s1;
    logic [ROWS_W-1:0]  r0;
    logic [ROWS_W-1:0]  r1;
    logic [PIDX_W-1:0]  nplanes;
    logic               err;
    logic [ALIGN_W-1:0] align;
    logic [BASE_W-1:0]  base;
  } dec_t;

  // aligned layout of one request, planes two and three share chroma values
  typedef struct packed {
    logic [STRIDE_W-1:0] st0;
    logic [STRIDE_W-1:0] st1;
    logic [ROWS_W-1:0]   r0;
    logic [ROWS_W-1:0]   r1;
    logic [PIDX_W-1:0]   nplanes;
    logic                err;
    logic [BASE_W-1:0]   base;
  } lay_t;

endpackage

/* design/fplc_if.sv */
// request and result channel interfaces of the frame plane layout calculator
// depends on fplc_pkg for the field widths
interface fplc_req_if;
  import fplc_pkg::*;

  logic               valid;
  logic               ready;
  logic [FW_W-1:0]    frame_width;
  logic [FH_W-1:0]    frame_height;
  logic [FMT_W-1:0]   format_code;
  logic [ALIGN_W-1:0] stride_align;
  logic [BASE_W-1:0]  base_address;

  modport source (
    output valid, frame_width, frame_height, format_code, stride_align, base_address,
    input  ready
  );
  modport sink (
    input  valid, frame_width, frame_height, format_code, stride_align, base_address,
    output ready
  );
endinterface

interface fplc_res_if;
  import fplc_pkg::*;

  logic                valid;
  logic                ready;
  logic [PIDX_W-1:0]   plane_index;
  logic [STRIDE_W-1:0] plane_stride;
  logic [ROWS_W-1:0]   plane_rows;
  logic [ADDR_W-1:0]   plane_address;
  logic [TOTAL_W-1:0]  total_size;
  logic                last_plane;
  logic                format_error;

  modport source (
    output valid, plane_index, plane_stride, plane_rows, plane_address, total_size,
           last_plane, format_error,
    input  ready
  );
  modport sink (
    input  valid, plane_index, plane_stride, plane_rows, plane_address, total_size,
           last_plane, format_error,
    output ready
  );
endinterface

/* design/fplc_front.sv */
// request intake: clamps the frame size, rounds to even per format and
// classifies the planes; depends on fplc_pkg and fplc_req_if
module fplc_front #(
  parameter int MAX_WIDTH  = fplc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fplc_pkg::MAX_HEIGHT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  fplc_req_if.sink       req_i,
  output logic           dec_valid_o,
  input  logic           dec_ready_i,
  output fplc_pkg::dec_t dec_o
);
  import fplc_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int MW = (WW > HW) ? WW : HW;
  localparam int DW = ((MW > FW_W) ? MW : FW_W) + 1;
  localparam int SW = DW + 2;

  logic [DW-1:0] w_in, h_in, w_sat, h_sat, w_ev, h_ev, h_evh;
  logic [SW-1:0] sat1, sat2, sat3, sat4, ev1, ev2, evh;
  logic [SW-1:0] s0_raw, s1_raw;
  logic [DW-1:0] r0_raw, r1_raw;
  logic [PIDX_W-1:0] np;
  logic          zero_dim;
  dec_t          dec_d;
  dec_t          dec_q;
  logic          dec_vld_q;
  logic          req_xfer;

  // dimension clamp and even rounding
  assign w_in  = DW'(req_i.frame_width);
  assign h_in  = DW'(req_i.frame_height);
  assign w_sat = (w_in > DW'(MAX_WIDTH))  ? DW'(MAX_WIDTH)  : w_in;
  assign h_sat = (h_in > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : h_in;
  assign w_ev  = w_sat + DW'(w_sat[0]);
  assign h_ev  = h_sat + DW'(h_sat[0]);
  assign h_evh = h_ev >> 1;
  assign zero_dim = (req_i.frame_width == '0) || (req_i.frame_height == '0);

  // row byte candidates
  assign sat1 = SW'(w_sat);
  assign sat2 = sat1 << 1;
  assign sat3 = sat2 + sat1;
  assign sat4 = sat1 << 2;
  assign ev1  = SW'(w_ev);
  assign ev2  = ev1 << 1;
  assign evh  = ev1 >> 1;

  // per-format plane shape
  always_comb begin
    s0_raw = '0;
    s1_raw = '0;
    r0_raw = '0;
    r1_raw = '0;
    np     = '0;
    case (req_i.format_code)
      FMT_YUV420P: begin
        s0_raw = ev1;  s1_raw = evh;  r0_raw = h_ev;  r1_raw = h_evh;  np = PIDX_W'(3);
      end
      FMT_YUV420P9, FMT_YUV420P10, FMT_YUV420P12, FMT_YUV420P14, FMT_YUV420P16: begin
        s0_raw = ev2;  s1_raw = ev1;  r0_raw = h_ev;  r1_raw = h_evh;  np = PIDX_W'(3);
      end
      FMT_YUV422P: begin
        s0_raw = ev1;  s1_raw = evh;  r0_raw = h_sat; r1_raw = h_sat;  np = PIDX_W'(3);
      end
      FMT_YUV422P9, FMT_YUV422P10, FMT_YUV422P12, FMT_YUV422P14, FMT_YUV422P16: begin
        s0_raw = ev2;  s1_raw = ev1;  r0_raw = h_sat; r1_raw = h_sat;  np = PIDX_W'(3);
      end
      FMT_YUV444P: begin
        s0_raw = sat1; s1_raw = sat1; r0_raw = h_sat; r1_raw = h_sat;  np = PIDX_W'(3);
      end
      FMT_YUV444P9, FMT_YUV444P10, FMT_YUV444P12, FMT_YUV444P14, FMT_YUV444P16: begin
        s0_raw = sat2; s1_raw = sat2; r0_raw = h_sat; r1_raw = h_sat;  np = PIDX_W'(3);
      end
      FMT_NV12, FMT_NV21: begin
        s0_raw = ev1;  s1_raw = ev1;  r0_raw = h_ev;  r1_raw = h_evh;  np = PIDX_W'(2);
      end
      FMT_P016: begin
        s0_raw = ev2;  s1_raw = ev2;  r0_raw = h_ev;  r1_raw = h_evh;  np = PIDX_W'(2);
      end
      FMT_NV16: begin
        s0_raw = ev1;  s1_raw = ev1;  r0_raw = h_ev;  r1_raw = h_ev;   np = PIDX_W'(2);
      end
      FMT_NV24, FMT_NV42: begin
        s0_raw = ev1;  s1_raw = ev2;  r0_raw = h_ev;  r1_raw = h_ev;   np = PIDX_W'(2);
      end
      FMT_GRAY8: begin
        s0_raw = sat1; r0_raw = h_sat; np = PIDX_W'(1);
      end
      FMT_GRAY16: begin
        s0_raw = sat2; r0_raw = h_sat; np = PIDX_W'(1);
      end
      FMT_GRAYF32, FMT_RGB32, FMT_BGR32: begin
        s0_raw = sat4; r0_raw = h_sat; np = PIDX_W'(1);
      end
      FMT_RGB24, FMT_BGR24: begin
        s0_raw = sat3; r0_raw = h_sat; np = PIDX_W'(1);
      end
      default: begin
        np = '0;
      end
    endcase
  end

  // clamp into the fixed internal widths
  always_comb begin
    dec_d.s0      = (s0_raw > SW'(RAW_MAX)) ? RAW_MAX : RAW_W'(s0_raw);
    dec_d.s1      = (s1_raw > SW'(RAW_MAX)) ? RAW_MAX : RAW_W'(s1_raw);
    dec_d.r0      = (r0_raw > DW'(ROWS_MAX)) ? ROWS_MAX : ROWS_W'(r0_raw);
    dec_d.r1      = (r1_raw > DW'(ROWS_MAX)) ? ROWS_MAX : ROWS_W'(r1_raw);
    dec_d.nplanes = np;
    dec_d.err     = zero_dim || (np == '0);
    dec_d.align   = (req_i.stride_align == '0) ? ALIGN_W'(1) : req_i.stride_align;
    dec_d.base    = req_i.base_address;
  end

  // intake register
  assign req_i.ready = !dec_vld_q || dec_ready_i;
  assign req_xfer    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_vld_q <= 1'b0;
    end else if (req_xfer) begin
      dec_vld_q <= 1'b1;
    end else if (dec_ready_i) begin
      dec_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      dec_q <= dec_d;
    end
  end

  assign dec_valid_o = dec_vld_q;
  assign dec_o       = dec_q;

  a_plane_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_vld_q && !dec_q.err |-> dec_q.nplanes != '0)
    else $error("valid layout request without planes");

endmodule

/* design/fplc_div.sv */
// stride alignment unit: remainder of luma and chroma row bytes by the
// alignment, one five-bit digit per step, then round up; depends on fplc_pkg
module fplc_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fplc_pkg::dec_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fplc_pkg::lay_t out_o
);
  import fplc_pkg::*;

  // one radix step: shift in a digit, conditionally subtract per bit
  function automatic logic [ALIGN_W-1:0] rem_step(logic [ALIGN_W-1:0] r,
                                                  logic [DIG_W-1:0]   dig,
                                                  logic [ALIGN_W-1:0] a);
    logic [ALIGN_W:0] t;
    t = {1'b0, r};
    for (int i = DIG_W - 1; i >= 0; i--) begin
      t = {t[ALIGN_W-1:0], dig[i]};
      if (t >= {1'b0, a}) begin
        t = t - {1'b0, a};
      end
    end
    return t[ALIGN_W-1:0];
  endfunction

  // round up to the alignment and saturate to the stride field
  function automatic logic [STRIDE_W-1:0] round_up(logic [RAW_W-1:0]   s,
                                                   logic [ALIGN_W-1:0] r,
                                                   logic [ALIGN_W-1:0] a);
    logic [ALIGN_W-1:0] adj;
    logic [RAW_W:0]     sum;
    adj = (r == '0) ? '0 : (a - r);
    sum = (RAW_W + 1)'(s) + (RAW_W + 1)'(adj);
    return (sum > (RAW_W + 1)'(STRIDE_MAX)) ? STRIDE_MAX : sum[STRIDE_W-1:0];
  endfunction

  dec_t               item_q;
  logic               busy_q;
  logic [DCNT_W-1:0]  cnt_q;
  logic [PAD_W-1:0]   sh0_q, sh1_q;
  logic [ALIGN_W-1:0] rem0_q, rem1_q;
  logic [PAD_W-1:0]   in_sh0, in_sh1;
  logic               done;
  logic               load;
  logic               out_xfer;

  assign done     = busy_q && (cnt_q == DCNT_W'(DIV_STEPS));
  assign in_ready_o = !busy_q || (done && out_ready_i);
  assign load     = in_valid_i && in_ready_o;
  assign out_xfer = done && out_ready_i;
  assign in_sh0   = PAD_W'(in_i.s0);
  assign in_sh1   = PAD_W'(in_i.s1);

  // control: busy flag and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= DCNT_W'(1);
    end else if (out_xfer) begin
      busy_q <= 1'b0;
    end else if (busy_q && !done) begin
      cnt_q  <= cnt_q + DCNT_W'(1);
    end
  end

  // datapath: first digit is taken in the load cycle
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_i;
      sh0_q  <= in_sh0 << DIG_W;
      sh1_q  <= in_sh1 << DIG_W;
      rem0_q <= rem_step('0, in_sh0[PAD_W-1 -: DIG_W], in_i.align);
      rem1_q <= rem_step('0, in_sh1[PAD_W-1 -: DIG_W], in_i.align);
    end else if (busy_q && !done) begin
      sh0_q  <= sh0_q << DIG_W;
      sh1_q  <= sh1_q << DIG_W;
      rem0_q <= rem_step(rem0_q, sh0_q[PAD_W-1 -: DIG_W], item_q.align);
      rem1_q <= rem_step(rem1_q, sh1_q[PAD_W-1 -: DIG_W], item_q.align);
    end
  end

  // aligned layout out
  always_comb begin
    out_o.st0     = round_up(item_q.s0, rem0_q, item_q.align);
    out_o.st1     = round_up(item_q.s1, rem1_q, item_q.align);
    out_o.r0      = item_q.r0;
    out_o.r1      = item_q.r1;
    out_o.nplanes = item_q.nplanes;
    out_o.err     = item_q.err;
    out_o.base    = item_q.base;
  end
  assign out_valid_o = done;

  a_keep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done |=> busy_q)
    else $error("alignment unit dropped an item in progress");

endmodule

/* design/fplc_queue.sv */
// short queue of aligned layouts between the alignment unit and the plane emitter
// depends on fplc_pkg
module fplc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  fplc_pkg::lay_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output fplc_pkg::lay_t pop_o
);
  import fplc_pkg::*;

  lay_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = entry_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("layout queue fill count out of range");

endmodule

/* design/fplc_back.sv */
// plane emitter: walks the planes of each layout, multiplies stride by rows,
// accumulates addresses and the total size; depends on fplc_pkg, fplc_res_if
module fplc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           lay_valid_i,
  output logic           lay_ready_o,
  input  fplc_pkg::lay_t lay_i,
  fplc_res_if.source     res_o
);
  import fplc_pkg::*;

  typedef struct packed {
    logic [PIDX_W-1:0]   idx;
    logic [STRIDE_W-1:0] stride;
    logic [ROWS_W-1:0]   rows;
    logic                first;
    logic                last;
    logic                err;
    logic [BASE_W-1:0]   base;
  } pl_t;

  logic [PIDX_W-1:0]   plane_q;
  pl_t                 pl_d, pl_q;
  logic                pl_vld_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ADDR_W-1:0]   addr_q, addr_cur;
  logic [ACC_W-1:0]    tot_q, tot_cur;
  logic                b_adv, a_adv, issue;

  logic                out_vld_q;
  logic [PIDX_W-1:0]   out_idx_q;
  logic [STRIDE_W-1:0] out_stride_q;
  logic [ROWS_W-1:0]   out_rows_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [TOTAL_W-1:0]  out_total_q;
  logic                out_last_q;
  logic                out_err_q;

  assign b_adv = !out_vld_q || res_o.ready;
  assign a_adv = !pl_vld_q || b_adv;
  assign issue = lay_valid_i && a_adv;

  // select the plane under the sequencer
  always_comb begin
    pl_d.idx    = plane_q;
    pl_d.first  = (plane_q == '0);
    pl_d.stride = pl_d.first ? lay_i.st0 : lay_i.st1;
    pl_d.rows   = pl_d.first ? lay_i.r0  : lay_i.r1;
    pl_d.err    = lay_i.err;
    pl_d.last   = lay_i.err || (plane_q == lay_i.nplanes - PIDX_W'(1));
    pl_d.base   = lay_i.base;
  end
  assign lay_ready_o = issue && pl_d.last;

  // plane sequencer and product stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q  <= '0;
      pl_vld_q <= 1'b0;
    end else begin
      if (issue) begin
        plane_q <= pl_d.last ? '0 : plane_q + PIDX_W'(1);
      end
      if (a_adv) begin
        pl_vld_q <= issue;
      end
    end
  end

  // product stage
  always_ff @(posedge clk_i) begin
    if (issue) begin
      pl_q   <= pl_d;
      prod_q <= PROD_W'(pl_d.stride) * PROD_W'(pl_d.rows);
    end
  end

  // running address and size
  assign addr_cur = pl_q.first ? ADDR_W'(pl_q.base) : addr_q;
  assign tot_cur  = (pl_q.first ? '0 : tot_q) + ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (b_adv && pl_vld_q) begin
      addr_q <= addr_cur + ADDR_W'(prod_q);
      tot_q  <= tot_cur;
      if (pl_q.err) begin
        out_idx_q    <= '0;
        out_stride_q <= '0;
        out_rows_q   <= '0;
        out_addr_q   <= '0;
        out_total_q  <= '0;
      end else begin
        out_idx_q    <= pl_q.idx;
        out_stride_q <= pl_q.stride;
        out_rows_q   <= pl_q.rows;
        out_addr_q   <= addr_cur;
        if (!pl_q.last) begin
          out_total_q <= '0;
        end else if (tot_cur > ACC_W'(TOTAL_MAX)) begin
          out_total_q <= TOTAL_MAX;
        end else begin
          out_total_q <= tot_cur[TOTAL_W-1:0];
        end
      end
      out_last_q <= pl_q.last;
      out_err_q  <= pl_q.err;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (b_adv) begin
      out_vld_q <= pl_vld_q;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.plane_index   = out_idx_q;
  assign res_o.plane_stride  = out_stride_q;
  assign res_o.plane_rows    = out_rows_q;
  assign res_o.plane_address = out_addr_q;
  assign res_o.total_size    = out_total_q;
  assign res_o.last_plane    = out_last_q;
  assign res_o.format_error  = out_err_q;

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.format_error |->
      res_o.last_plane && res_o.plane_index == '0 && res_o.total_size == '0)
    else $error("error result is not a single cleared result");

  a_total_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.last_plane |-> res_o.total_size == '0 && !res_o.format_error)
    else $error("total size shown before the last plane");

endmodule

/* design/frame_plane_layout_calculator.sv */
// a request is registered at intake, in the alignment unit, queue and plane emitter
// the radix-32 stride alignment unit takes a new request only as the last one leaves;
// the emitter gives one plane per cycle unless stalled, up to three planes a request
// reset: asynchronous, active low; clears handshake and sequencer state only
// top level: intake -> alignment unit -> layout queue -> plane emitter
// depends on fplc_pkg and fplc_if
module frame_plane_layout_calculator #(
  parameter int MAX_WIDTH  = fplc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fplc_pkg::MAX_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fplc_req_if.sink   req_i,
  fplc_res_if.source res_o
);
  import fplc_pkg::*;

  dec_t dec;
  logic dec_valid, dec_ready;
  lay_t lay_in, lay_out;
  logic lay_in_valid, lay_in_ready;
  logic lay_out_valid, lay_out_ready;

  // request intake and classification
  fplc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .dec_valid_o (dec_valid),
    .dec_ready_i (dec_ready),
    .dec_o       (dec)
  );

  // stride alignment
  fplc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_i        (dec),
    .out_valid_o (lay_in_valid),
    .out_ready_i (lay_in_ready),
    .out_o       (lay_in)
  );

  // decoupling queue
  fplc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (lay_in_valid),
    .push_ready_o (lay_in_ready),
    .push_i       (lay_in),
    .pop_valid_o  (lay_out_valid),
    .pop_ready_i  (lay_out_ready),
    .pop_o        (lay_out)
  );

  // plane emitter
  fplc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lay_valid_i (lay_out_valid),
    .lay_ready_o (lay_out_ready),
    .lay_i       (lay_out),
    .res_o       (res_o)
  );

endmodule

/* tb/sv/fplc_layout_checker.sv */
// plane layout checker: watches request and result transfers and checks every plane
// depends on fplc_pkg and the fplc_req_if / fplc_res_if interfaces
module fplc_layout_checker
  import fplc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  fplc_req_if   req_mon,
  fplc_res_if   res_mon,
  output int    mismatch_count,
  output int    planes_outstanding
);

  // one expected plane result
  typedef struct packed {
    logic [PIDX_W-1:0]   pidx;
    logic [STRIDE_W-1:0] stride;
    logic [ROWS_W-1:0]   rows;
    logic [ADDR_W-1:0]   addr;
    logic [TOTAL_W-1:0]  total;
    logic                last;
    logic                err;
  } plane_rec_t;

  plane_rec_t layout_q[$];

  function automatic logic [63:0] round_even(input logic [63:0] v);
    return (v + 64'd1) & ~64'd1;
  endfunction

  // derive the planes of one request and queue them in order
  function automatic void predict_layout(input logic [FW_W-1:0]    fw,
                                         input logic [FH_W-1:0]    fh,
                                         input logic [FMT_W-1:0]   code,
                                         input logic [ALIGN_W-1:0] align,
                                         input logic [BASE_W-1:0]  base);
    logic [63:0] w, h, a, bps, off, total, st, rows;
    logic [63:0] row_bytes [MAX_PLANES];
    logic [63:0] row_cnt [MAX_PLANES];
    int          nplanes;
    plane_rec_t  rec;

    w = (64'(fw) > 64'(MAX_WIDTH)) ? 64'(MAX_WIDTH) : 64'(fw);
    h = (64'(fh) > 64'(MAX_HEIGHT)) ? 64'(MAX_HEIGHT) : 64'(fh);
    a = (align == '0) ? 64'd1 : 64'(align);
    for (int i = 0; i < MAX_PLANES; i++) begin
      row_bytes[i] = '0;
      row_cnt[i]   = '0;
    end
    nplanes = 0;

    // per-format shape; zero size leaves no planes
    if (w != 0 && h != 0) begin
      if (code <= FMT_YUV420P16) begin
        bps = (code == FMT_YUV420P) ? 64'd1 : 64'd2;
        w = round_even(w);
        h = round_even(h);
        row_bytes[0] = w * bps;
        row_bytes[1] = (w / 2) * bps;
        row_bytes[2] = row_bytes[1];
        row_cnt[0] = h;
        row_cnt[1] = h / 2;
        row_cnt[2] = h / 2;
        nplanes = 3;
      end else if (code <= FMT_YUV422P16) begin
        bps = (code == FMT_YUV422P) ? 64'd1 : 64'd2;
        w = round_even(w);
        row_bytes[0] = w * bps;
        row_bytes[1] = (w / 2) * bps;
        row_bytes[2] = row_bytes[1];
        row_cnt[0] = h;
        row_cnt[1] = h;
        row_cnt[2] = h;
        nplanes = 3;
      end else if (code <= FMT_YUV444P16) begin
        bps = (code == FMT_YUV444P) ? 64'd1 : 64'd2;
        row_bytes[0] = w * bps;
        row_bytes[1] = row_bytes[0];
        row_bytes[2] = row_bytes[0];
        row_cnt[0] = h;
        row_cnt[1] = h;
        row_cnt[2] = h;
        nplanes = 3;
      end else if (code <= FMT_NV42) begin
        // semi-planar: luma plus one interleaved chroma plane
        w = round_even(w);
        h = round_even(h);
        row_cnt[0] = h;
        if (code <= FMT_NV21) begin
          row_bytes[0] = w;
          row_bytes[1] = w;
          row_cnt[1]   = h / 2;
        end else if (code == FMT_P016) begin
          row_bytes[0] = 2 * w;
          row_bytes[1] = 2 * w;
          row_cnt[1]   = h / 2;
        end else if (code == FMT_NV16) begin
          row_bytes[0] = w;
          row_bytes[1] = w;
          row_cnt[1]   = h;
        end else begin
          row_bytes[0] = w;
          row_bytes[1] = 2 * w;
          row_cnt[1]   = h;
        end
        nplanes = 2;
      end else begin
        // packed single-plane formats
        nplanes    = 1;
        row_cnt[0] = h;
        case (code)
          FMT_GRAY8:                          row_bytes[0] = w;
          FMT_GRAY16:                         row_bytes[0] = 2 * w;
          FMT_GRAYF32, FMT_RGB32, FMT_BGR32:  row_bytes[0] = 4 * w;
          FMT_RGB24, FMT_BGR24:               row_bytes[0] = 3 * w;
          default:                            nplanes = 0;
        endcase
      end
    end

    // unknown format or empty frame: a single error result
    if (nplanes == 0) begin
      rec      = '0;
      rec.last = 1'b1;
      rec.err  = 1'b1;
      layout_q.push_back(rec);
      return;
    end

    // align strides and lay the planes out back to back
    off   = '0;
    total = '0;
    for (int i = 0; i < nplanes; i++) begin
      st   = ((row_bytes[i] + a - 1) / a) * a;
      rows = row_cnt[i];
      if (st > 64'(STRIDE_MAX)) st = 64'(STRIDE_MAX);
      if (rows > 64'(ROWS_MAX)) rows = 64'(ROWS_MAX);
      rec        = '0;
      rec.pidx   = PIDX_W'(i);
      rec.stride = STRIDE_W'(st);
      rec.rows   = ROWS_W'(rows);
      rec.addr   = ADDR_W'(64'(base) + off);
      off   = off + st * rows;
      total = total + st * rows;
      if (i == nplanes - 1) begin
        rec.total = (total > 64'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(total);
        rec.last  = 1'b1;
      end
      layout_q.push_back(rec);
    end
  endfunction

  // sample both channels at the clock edge
  always @(posedge clk_i) begin
    plane_rec_t got, exp_rec;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) begin
        predict_layout(req_mon.frame_width, req_mon.frame_height, req_mon.format_code,
                       req_mon.stride_align, req_mon.base_address);
      end
      if (res_mon.valid && res_mon.ready) begin
        got = '{res_mon.plane_index, res_mon.plane_stride, res_mon.plane_rows,
                res_mon.plane_address, res_mon.total_size, res_mon.last_plane,
                res_mon.format_error};
        if (layout_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected plane result: idx=%0d stride=%0d rows=%0d addr=%h",
                     got.pidx, got.stride, got.rows, got.addr);
        end else begin
          exp_rec = layout_q.pop_front();
          if (got.pidx !== exp_rec.pidx || got.stride !== exp_rec.stride ||
              got.rows !== exp_rec.rows || got.addr !== exp_rec.addr ||
              got.total !== exp_rec.total || got.last !== exp_rec.last ||
              got.err !== exp_rec.err) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display({"plane mismatch exp: idx=%0d stride=%0d rows=%0d addr=%h",
                        " total=%0d last=%b err=%b"},
                       exp_rec.pidx, exp_rec.stride, exp_rec.rows, exp_rec.addr,
                       exp_rec.total, exp_rec.last, exp_rec.err);
              $display({"plane mismatch got: idx=%0d stride=%0d rows=%0d addr=%h",
                        " total=%0d last=%b err=%b"},
                       got.pidx, got.stride, got.rows, got.addr,
                       got.total, got.last, got.err);
            end
          end
        end
      end
    end
    planes_outstanding <= layout_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// top of the frame plane layout calculator testbench: clock, reset, request stimulus
// and result back-pressure; depends on fplc_pkg, the interfaces and fplc_layout_checker
module tb_top;
  import fplc_pkg::*;

  localparam logic [FMT_W-1:0] FMT_UNKNOWN = 5'd31;
  localparam int RANDOM_CHUNKS = 10;
  localparam int CHUNK_ITEMS   = 50;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic steady_flow;
  int   mismatch_count;
  int   planes_outstanding;

  fplc_req_if req_if ();
  fplc_res_if res_if ();

  frame_plane_layout_calculator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  fplc_layout_checker layout_chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_mon            (req_if),
    .res_mon            (res_if),
    .mismatch_count     (mismatch_count),
    .planes_outstanding (planes_outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // idle cycles before the next transfer on either side
  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_request(input logic [FW_W-1:0]    fw,
                              input logic [FH_W-1:0]    fh,
                              input logic [FMT_W-1:0]   code,
                              input logic [ALIGN_W-1:0] align,
                              input logic [BASE_W-1:0]  base);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.frame_width  <= fw;
    req_if.frame_height <= fh;
    req_if.format_code  <= code;
    req_if.stride_align <= align;
    req_if.base_address <= base;
    req_if.valid        <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // hold requests back until every queued plane has come out
  task automatic drain_layouts();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (planes_outstanding != 0);
  endtask

  // result back-pressure
  initial begin
    int gap;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  // stimulus and verdict
  initial begin
    logic [FW_W-1:0]    fw;
    logic [FH_W-1:0]    fh;
    logic [FMT_W-1:0]   code;
    logic [ALIGN_W-1:0] align;
    logic [BASE_W-1:0]  base;
    int                 drain_cycles;

    rst_ni              = 1'b0;
    steady_flow         = 1'b0;
    req_if.valid        = 1'b0;
    req_if.frame_width  = '0;
    req_if.frame_height = '0;
    req_if.format_code  = '0;
    req_if.stride_align = '0;
    req_if.base_address = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed sweep over every format code, mixed with size and alignment extremes
    for (int k = 0; k < 32; k++) begin
      case (k % 8)
        0: fw = 14'd1;
        1: fw = 14'd8192;
        2: fw = 14'd16383;
        3: fw = 14'd0;
        4: fw = 14'd8191;
        5: fw = 14'd3;
        6: fw = 14'd9000;
        default: fw = 14'd1023;
      endcase
      case ((k + 3) % 8)
        0: fh = 14'd1;
        1: fh = 14'd8192;
        2: fh = 14'd16383;
        3: fh = 14'd7;
        4: fh = 14'd0;
        5: fh = 14'd8191;
        6: fh = 14'd3;
        default: fh = 14'd4097;
      endcase
      case ((k / 2) % 8)
        0: align = 13'd1;
        1: align = 13'd4096;
        2: align = 13'd0;
        3: align = 13'd8191;
        4: align = 13'd64;
        5: align = 13'd3;
        6: align = 13'd1;
        default: align = 13'd4095;
      endcase
      case (k % 3)
        0: base = 32'h0000_0000;
        1: base = 32'hffff_ffff;
        default: base = $urandom();
      endcase
      send_request(fw, fh, FMT_W'(k), align, base);
    end
    drain_layouts();

    // random requests in chunks, some without any idling
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      steady_flow = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0: fw = FW_W'($urandom_range(0, 16383));
          1: fw = FW_W'($urandom_range(8000, 8192));
          2, 3: fw = FW_W'($urandom_range(1, 64));
          default: fw = FW_W'($urandom_range(1, 8192));
        endcase
        case ($urandom_range(0, 9))
          0: fh = FH_W'($urandom_range(0, 16383));
          1: fh = FH_W'($urandom_range(8000, 8192));
          2, 3: fh = FH_W'($urandom_range(1, 64));
          default: fh = FH_W'($urandom_range(1, 8192));
        endcase
        code = ($urandom_range(0, 15) == 0) ? FMT_UNKNOWN : FMT_W'($urandom_range(0, 30));
        case ($urandom_range(0, 4))
          0: align = ALIGN_W'($urandom_range(0, 8191));
          1, 2: align = ALIGN_W'(1 << $urandom_range(0, 12));
          3: align = ALIGN_W'($urandom_range(0, 16));
          default: align = ALIGN_W'($urandom_range(1, 4096));
        endcase
        base = $urandom();
        send_request(fw, fh, code, align, base);
      end
      if ($urandom_range(0, 2) == 0) drain_layouts();
    end
    steady_flow = 1'b0;
    req_if.valid <= 1'b0;

    // wait for the last planes, then idle before the verdict
    drain_cycles = 0;
    while (planes_outstanding != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0 && planes_outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
